FILE: rtl/core/ebis_pkg.sv
// ----------------------------------------------------------------------------
// ebis_pkg: shared types and constants of the engine board input supervisor
// Widths, register indexes, reset values and the word structs.
// ----------------------------------------------------------------------------
package ebis_pkg;

   localparam int unsigned NUM_GEARS  = 6;
   localparam int unsigned GEAR_W     = 3;
   localparam int unsigned TH_W       = 8;
   localparam int unsigned TIME_W     = 32;
   localparam int unsigned MS_W       = 16;
   localparam int unsigned ADC_W      = 10;
   localparam int unsigned RPM_W      = 16;
   localparam int unsigned MODE_W     = 2;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = NUM_GEARS * TH_W;
   // adc * 255 fits in this many bits, plus the divide-by-1023 correction
   localparam int unsigned SCALE_W    = ADC_W + TH_W;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CLUTCH_POL    = 3'd0,
      CSR_TIPOVER_POL   = 3'd1,
      CSR_GEAR_THRESH   = 3'd2,
      CSR_SPEED_MODE    = 3'd3,
      CSR_TIP_DEBOUNCE  = 3'd4,
      CSR_BULB_CHECK    = 3'd5,
      CSR_HEATER_DELAY  = 3'd6
   } csr_index_type;

   localparam logic [CSR_DATA_W-1:0] GEAR_THRESH_RESET = 48'hFFAA_8B6C_4D2E;
   localparam logic [MS_W-1:0]       TIP_DEBOUNCE_RESET = 16'd500;
   localparam logic [MS_W-1:0]       BULB_CHECK_RESET   = 16'd2000;
   localparam logic [MS_W-1:0]       HEATER_DELAY_RESET = 16'd3000;

   typedef struct packed {
      logic                  clutch_active_high;
      logic                  tipover_active_high;
      logic [CSR_DATA_W-1:0] gear_thresholds;
      logic [MODE_W-1:0]     speed_based_gear_mode;
      logic [MS_W-1:0]       tip_debounce_ms;
      logic [MS_W-1:0]       bulb_check_ms;
      logic [MS_W-1:0]       heater_delay_ms;
   } cfg_type;

   typedef struct packed {
      logic [TIME_W-1:0] now_ms;
      logic              neutral_level;
      logic              clutch_level;
      logic              fault_level;
      logic              tipover_level;
      logic [ADC_W-1:0]  gear_adc;
      logic              engine_protect_active;
      logic [RPM_W-1:0]  engine_rpm;
   } sample_type;

   typedef struct packed {
      logic              in_neutral;
      logic              clutch_pulled;
      logic              driver_fault;
      logic [TH_W-1:0]   gear_raw;
      logic [GEAR_W-1:0] gear;
   } decode_type;

   typedef struct packed {
      logic              in_neutral;
      logic              clutch_pulled;
      logic              driver_fault;
      logic [TH_W-1:0]   gear_raw;
      logic [GEAR_W-1:0] gear;
      logic              publish_gear;
      logic              tipped_over;
      logic              outputs_enabled;
      logic              fault_lamp_on;
      logic              o2_heater_on;
   } result_type;

   // Control from the pipeline to one elapsed-time tracker
   typedef struct packed {
      logic step;    // a word moves to the result register this cycle
      logic active;  // the tracked condition holds for that word
   } timer_ctl_type;

endpackage

FILE: rtl/core/ebis_if.sv
// ----------------------------------------------------------------------------
// ebis_if: valid/ready channels of the engine board input supervisor
// One interface for the sample channel and one for the result channel.
// ----------------------------------------------------------------------------
interface ebis_req_if;
   logic                            valid;
   logic                            ready;
   logic [ebis_pkg::TIME_W-1:0]     now_ms;
   logic                            neutral_level;
   logic                            clutch_level;
   logic                            fault_level;
   logic                            tipover_level;
   logic [ebis_pkg::ADC_W-1:0]      gear_adc;
   logic                            engine_protect_active;
   logic [ebis_pkg::RPM_W-1:0]      engine_rpm;

   modport source (
      output valid, now_ms, neutral_level, clutch_level, fault_level,
             tipover_level, gear_adc, engine_protect_active, engine_rpm,
      input  ready
   );
   modport sink (
      input  valid, now_ms, neutral_level, clutch_level, fault_level,
             tipover_level, gear_adc, engine_protect_active, engine_rpm,
      output ready
   );
endinterface

interface ebis_rsp_if;
   logic                            valid;
   logic                            ready;
   logic                            in_neutral;
   logic                            clutch_pulled;
   logic                            driver_fault;
   logic [ebis_pkg::TH_W-1:0]       gear_raw;
   logic [ebis_pkg::GEAR_W-1:0]     gear;
   logic                            publish_gear;
   logic                            tipped_over;
   logic                            outputs_enabled;
   logic                            fault_lamp_on;
   logic                            o2_heater_on;

   modport source (
      output valid, in_neutral, clutch_pulled, driver_fault, gear_raw, gear,
             publish_gear, tipped_over, outputs_enabled, fault_lamp_on,
             o2_heater_on,
      input  ready
   );
   modport sink (
      input  valid, in_neutral, clutch_pulled, driver_fault, gear_raw, gear,
             publish_gear, tipped_over, outputs_enabled, fault_lamp_on,
             o2_heater_on,
      output ready
   );
endinterface

FILE: rtl/core/ebis_csr.sv
// ----------------------------------------------------------------------------
// ebis_csr: configuration registers
// Write-only register file, one register per index.
// ----------------------------------------------------------------------------
module ebis_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [ebis_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ebis_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output ebis_pkg::cfg_type                 cfg
);

   ebis_pkg::cfg_type cfg_ff;
   ebis_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (ebis_pkg::csr_index_type'(csr_index))
            ebis_pkg::CSR_CLUTCH_POL:   cfg_in.clutch_active_high = csr_wdata[0];
            ebis_pkg::CSR_TIPOVER_POL:  cfg_in.tipover_active_high = csr_wdata[0];
            ebis_pkg::CSR_GEAR_THRESH:  cfg_in.gear_thresholds = csr_wdata;
            ebis_pkg::CSR_SPEED_MODE:
               cfg_in.speed_based_gear_mode = csr_wdata[ebis_pkg::MODE_W-1:0];
            ebis_pkg::CSR_TIP_DEBOUNCE:
               cfg_in.tip_debounce_ms = csr_wdata[ebis_pkg::MS_W-1:0];
            ebis_pkg::CSR_BULB_CHECK:
               cfg_in.bulb_check_ms = csr_wdata[ebis_pkg::MS_W-1:0];
            ebis_pkg::CSR_HEATER_DELAY:
               cfg_in.heater_delay_ms = csr_wdata[ebis_pkg::MS_W-1:0];
            default: ;  // drop writes to unused indexes
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.clutch_active_high    <= 1'b0;
         cfg_ff.tipover_active_high   <= 1'b1;
         cfg_ff.gear_thresholds       <= ebis_pkg::GEAR_THRESH_RESET;
         cfg_ff.speed_based_gear_mode <= '0;
         cfg_ff.tip_debounce_ms       <= ebis_pkg::TIP_DEBOUNCE_RESET;
         cfg_ff.bulb_check_ms         <= ebis_pkg::BULB_CHECK_RESET;
         cfg_ff.heater_delay_ms       <= ebis_pkg::HEATER_DELAY_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: rtl/core/ebis_decode.sv
// ----------------------------------------------------------------------------
// ebis_decode: switch and gear decode
// Decodes switch levels, scales the gear sensor and picks the gear number.
// ----------------------------------------------------------------------------
module ebis_decode (
   input  ebis_pkg::sample_type  sample,
   input  ebis_pkg::cfg_type     cfg,
   output ebis_pkg::decode_type  dec
);

   logic [ebis_pkg::SCALE_W-1:0] prod;
   logic [ebis_pkg::SCALE_W-1:0] quot_sum;
   logic [ebis_pkg::TH_W-1:0]    raw;
   logic [ebis_pkg::GEAR_W-1:0]  gear_num;

   // adc * 255, then floor(x / 1023) as (x + (x >> 10) + 1) >> 10
   assign prod     = {sample.gear_adc, {ebis_pkg::TH_W{1'b0}}}
                     - ebis_pkg::SCALE_W'(sample.gear_adc);
   assign quot_sum = prod + (prod >> ebis_pkg::ADC_W) + ebis_pkg::SCALE_W'(1);
   assign raw      = quot_sum[ebis_pkg::SCALE_W-1 -: ebis_pkg::TH_W];

   // First threshold not exceeded wins; scan from the top so the lowest sticks
   always_comb begin
      gear_num = ebis_pkg::GEAR_W'(ebis_pkg::NUM_GEARS);
      for (int i = ebis_pkg::NUM_GEARS - 1; i >= 0; i--) begin
         if (raw <= cfg.gear_thresholds[i*ebis_pkg::TH_W +: ebis_pkg::TH_W]) begin
            gear_num = ebis_pkg::GEAR_W'(i + 1);
         end
      end
   end

   assign dec.in_neutral    = ~sample.neutral_level;
   assign dec.clutch_pulled = (sample.clutch_level == cfg.clutch_active_high);
   assign dec.driver_fault  = ~sample.fault_level;
   assign dec.gear_raw      = raw;
   assign dec.gear          = sample.neutral_level ? gear_num : '0;

endmodule

FILE: rtl/core/ebis_timer.sv
// ----------------------------------------------------------------------------
// ebis_timer: elapsed-time tracker
// Latches the start time when a condition begins and flags when it has lasted.
// ----------------------------------------------------------------------------
module ebis_timer (
   input  logic                           clock,
   input  logic                           reset,
   input  ebis_pkg::timer_ctl_type        ctl,
   input  logic [ebis_pkg::TIME_W-1:0]    now_ms,
   input  logic [ebis_pkg::MS_W-1:0]      limit_ms,
   output logic                           met
);

   logic                        timing_ff;
   logic                        timing_in;
   logic [ebis_pkg::TIME_W-1:0] start_ff;
   logic [ebis_pkg::TIME_W-1:0] start_in;
   logic [ebis_pkg::TIME_W-1:0] start_eff;
   logic [ebis_pkg::TIME_W-1:0] elapsed;

   // A fresh start sees zero elapsed time; wrap is handled by the modulo subtract
   assign start_eff = timing_ff ? start_ff : now_ms;
   assign elapsed   = now_ms - start_eff;
   assign met       = ctl.active && (elapsed >= ebis_pkg::TIME_W'(limit_ms));

   assign timing_in = ctl.step ? ctl.active : timing_ff;
   assign start_in  = (ctl.step && ctl.active && !timing_ff) ? now_ms : start_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         timing_ff <= 1'b0;
      end else begin
         timing_ff <= timing_in;
      end
   end

   always_ff @(posedge clock) begin
      start_ff <= start_in;
   end

   a_start_held: assert property (@(posedge clock) disable iff (reset)
      ctl.step && ctl.active && timing_ff |=> $stable(start_ff))
      else $error("start time moved while the condition persisted");

   a_fall_on_drop: assert property (@(posedge clock)
      $fell(timing_ff) |-> $past(reset) || $past(ctl.step && !ctl.active))
      else $error("timing flag cleared without the condition dropping");

endmodule

FILE: rtl/core/engine_board_input_supervisor.sv
// ----------------------------------------------------------------------------
// engine_board_input_supervisor: top level
// Decodes one service sample word into one status word.
// ----------------------------------------------------------------------------
// The block takes one sample word per clock while the result side keeps
// up, and returns one status word per sample, in order. A sample is captured
// in the input register, decoded by shallow logic (switch decode, 10-bit to
// 8-bit gear scaling, six threshold compares, two 32-bit elapsed-time
// compares) and lands in the result register, from which the result channel
// offers it; throughput is one word per clock while results are taken; the
// result register and the input register stall together only when the result
// is not taken. Tip-over and
// engine-run timers advance when a word moves into the result register, so
// their state follows sample order. Configuration takes effect on the word
// that moves after the write; write it while the block is idle.
module engine_board_input_supervisor (
   input  logic                              clock,
   input  logic                              reset,
   ebis_req_if.sink                          req_chan,
   ebis_rsp_if.source                        rsp_chan,
   input  logic                              csr_wr_en,
   input  logic [ebis_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ebis_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   ebis_pkg::cfg_type        cfg;
   ebis_pkg::sample_type     req_sample;
   ebis_pkg::sample_type     s1_data_ff;
   ebis_pkg::result_type     s2_data_ff;
   ebis_pkg::result_type     result;
   ebis_pkg::decode_type     dec;
   ebis_pkg::timer_ctl_type  tip_ctl;
   ebis_pkg::timer_ctl_type  run_ctl;
   logic                     s1_valid_ff;
   logic                     s1_valid_in;
   logic                     s2_valid_ff;
   logic                     s2_valid_in;
   logic                     accept;
   logic                     advance;
   logic                     tipped;
   logic                     heater;
   logic                     bulb_check;

   ebis_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Gather the incoming word
   assign req_sample.now_ms                = req_chan.now_ms;
   assign req_sample.neutral_level         = req_chan.neutral_level;
   assign req_sample.clutch_level          = req_chan.clutch_level;
   assign req_sample.fault_level           = req_chan.fault_level;
   assign req_sample.tipover_level         = req_chan.tipover_level;
   assign req_sample.gear_adc              = req_chan.gear_adc;
   assign req_sample.engine_protect_active = req_chan.engine_protect_active;
   assign req_sample.engine_rpm            = req_chan.engine_rpm;

   // Advance when the input register holds a word and the result slot frees up
   assign advance        = s1_valid_ff && (!s2_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || advance;
   assign accept         = req_chan.valid && req_chan.ready;

   assign s1_valid_in = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
   assign s2_valid_in = advance ? 1'b1 : (rsp_chan.ready ? 1'b0 : s2_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_data_ff <= req_sample;
      end
      if (advance) begin
         s2_data_ff <= result;
      end
   end

   ebis_decode u_decode (
      .sample (s1_data_ff),
      .cfg    (cfg),
      .dec    (dec)
   );

   // Tip-over debounce: condition is the sensor at its "down" level
   assign tip_ctl.step   = advance;
   assign tip_ctl.active = (s1_data_ff.tipover_level == cfg.tipover_active_high);

   ebis_timer u_tip_timer (
      .clock    (clock),
      .reset    (reset),
      .ctl      (tip_ctl),
      .now_ms   (s1_data_ff.now_ms),
      .limit_ms (cfg.tip_debounce_ms),
      .met      (tipped)
   );

   // Heater delay: condition is a nonzero engine speed
   assign run_ctl.step   = advance;
   assign run_ctl.active = (s1_data_ff.engine_rpm != '0);

   ebis_timer u_run_timer (
      .clock    (clock),
      .reset    (reset),
      .ctl      (run_ctl),
      .now_ms   (s1_data_ff.now_ms),
      .limit_ms (cfg.heater_delay_ms),
      .met      (heater)
   );

   // Hold the lamp on during the power-up bulb check
   assign bulb_check = s1_data_ff.now_ms < ebis_pkg::TIME_W'(cfg.bulb_check_ms);

   assign result.in_neutral      = dec.in_neutral;
   assign result.clutch_pulled   = dec.clutch_pulled;
   assign result.driver_fault    = dec.driver_fault;
   assign result.gear_raw        = dec.gear_raw;
   assign result.gear            = dec.gear;
   assign result.publish_gear    = (cfg.speed_based_gear_mode == '0);
   assign result.tipped_over     = tipped;
   assign result.outputs_enabled = !tipped;
   assign result.fault_lamp_on   = bulb_check || s1_data_ff.engine_protect_active
                                   || dec.driver_fault || tipped;
   assign result.o2_heater_on    = heater;

   // Drive the result channel from the result register
   assign rsp_chan.valid           = s2_valid_ff;
   assign rsp_chan.in_neutral      = s2_data_ff.in_neutral;
   assign rsp_chan.clutch_pulled   = s2_data_ff.clutch_pulled;
   assign rsp_chan.driver_fault    = s2_data_ff.driver_fault;
   assign rsp_chan.gear_raw        = s2_data_ff.gear_raw;
   assign rsp_chan.gear            = s2_data_ff.gear;
   assign rsp_chan.publish_gear    = s2_data_ff.publish_gear;
   assign rsp_chan.tipped_over     = s2_data_ff.tipped_over;
   assign rsp_chan.outputs_enabled = s2_data_ff.outputs_enabled;
   assign rsp_chan.fault_lamp_on   = s2_data_ff.fault_lamp_on;
   assign rsp_chan.o2_heater_on    = s2_data_ff.o2_heater_on;

   a_empty_takes: assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |-> req_chan.ready)
      else $error("input register empty but the sample channel stalls");

   a_neutral_gear: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.in_neutral |-> rsp_chan.gear == '0)
      else $error("gear reported while in neutral");

endmodule

FILE: test/engine_board_input_supervisor_test.sv
// ----------------------------------------------------------------------------
// engine_board_input_supervisor_test: self-checking bench of the supervisor
// Sends service sample words through the valid/ready channels, predicts each
// status word from its own copy of the registers and timers or takes a pinned
// one, and checks every returned status word field by field, in order.
// ----------------------------------------------------------------------------
module engine_board_input_supervisor_test;
   import ebis_pkg::*;

   localparam int PHASES       = 8;
   localparam int PHASE_WORDS  = 240;
   localparam int QUIET_LIMIT  = 5000;
   localparam int PROBE_COUNT  = 21;
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 3'd7;

   // One word as offered: the sample, and a status typed in by hand where
   // it can be read straight off the spec (pinned), else left to prediction.
   typedef struct packed {
      sample_type stim;
      logic       pinned;
      result_type status;
   } probe_row_type;

   localparam result_type FREE = '0;

   // Directed words, all under the reset settings. Reading order of a row:
   // now_ms, neutral, clutch, fault, tip-over, adc, protect, rpm; then the
   // pinned flag; then in_neutral, clutch, fault, raw, gear, publish,
   // tipped, enabled, lamp, heater.
   localparam probe_row_type PROBE_ROWS [PROBE_COUNT] = '{
      // power-up: neutral closed, clutch pulled (active low), lamp bulb check
      '{'{32'd0, 1'b0, 1'b0, 1'b1, 1'b0, 10'd0, 1'b0, 16'd0}, 1'b1,
        '{1'b1, 1'b1, 1'b0, 8'd0, 3'd0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0}},
      // bulb check just over, full-scale adc lands on the last gear
      '{'{32'd2000, 1'b1, 1'b1, 1'b1, 1'b0, 10'd1023, 1'b0, 16'd0}, 1'b1,
        '{1'b0, 1'b0, 1'b0, 8'd255, 3'd6, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0}},
      // last bulb check millisecond, driver fault, adc zero is first gear
      '{'{32'd1999, 1'b1, 1'b0, 1'b0, 1'b0, 10'd0, 1'b0, 16'd0}, 1'b1,
        '{1'b0, 1'b1, 1'b1, 8'd0, 3'd1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0}},
      // engine protection alone lights the lamp
      '{'{32'd5000, 1'b1, 1'b1, 1'b1, 1'b0, 10'd0, 1'b1, 16'd0}, 1'b1,
        '{1'b0, 1'b0, 1'b0, 8'd0, 3'd1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0}},
      // neutral forces gear zero whatever the sensor reads
      '{'{32'hFFFF_FFFF, 1'b0, 1'b1, 1'b1, 1'b0, 10'd1023, 1'b0, 16'd0}, 1'b1,
        '{1'b1, 1'b0, 1'b0, 8'd255, 3'd0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0}},
      // scaling around the first threshold, near full scale and at mid scale
      '{'{32'd5001, 1'b1, 1'b1, 1'b1, 1'b0, 10'd188, 1'b0, 16'd0}, 1'b0, FREE},
      '{'{32'd5002, 1'b1, 1'b1, 1'b1, 1'b0, 10'd189, 1'b0, 16'd0}, 1'b0, FREE},
      '{'{32'd5003, 1'b1, 1'b1, 1'b1, 1'b0, 10'd1022, 1'b0, 16'd0}, 1'b0, FREE},
      '{'{32'd5004, 1'b1, 1'b1, 1'b1, 1'b0, 10'd512, 1'b0, 16'd0}, 1'b0, FREE},
      // tip-over timer: start, one short of debounce, exactly met, dropped
      '{'{32'd10000, 1'b1, 1'b1, 1'b1, 1'b1, 10'd0, 1'b0, 16'd0}, 1'b1,
        '{1'b0, 1'b0, 1'b0, 8'd0, 3'd1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0}},
      '{'{32'd10499, 1'b1, 1'b1, 1'b1, 1'b1, 10'd0, 1'b0, 16'd0}, 1'b0, FREE},
      '{'{32'd10500, 1'b1, 1'b1, 1'b1, 1'b1, 10'd0, 1'b0, 16'd0}, 1'b1,
        '{1'b0, 1'b0, 1'b0, 8'd0, 3'd1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0}},
      '{'{32'd10501, 1'b1, 1'b1, 1'b1, 1'b0, 10'd0, 1'b0, 16'd0}, 1'b1,
        '{1'b0, 1'b0, 1'b0, 8'd0, 3'd1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0}},
      // heater timer: start at top rpm, one short, exactly met, engine stops
      '{'{32'd20000, 1'b1, 1'b1, 1'b1, 1'b0, 10'd0, 1'b0, 16'd65535}, 1'b0, FREE},
      '{'{32'd22999, 1'b1, 1'b1, 1'b1, 1'b0, 10'd0, 1'b0, 16'd1}, 1'b0, FREE},
      '{'{32'd23000, 1'b1, 1'b1, 1'b1, 1'b0, 10'd0, 1'b0, 16'd1}, 1'b1,
        '{1'b0, 1'b0, 1'b0, 8'd0, 3'd1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1}},
      '{'{32'd23001, 1'b1, 1'b1, 1'b1, 1'b0, 10'd0, 1'b0, 16'd0}, 1'b1,
        '{1'b0, 1'b0, 1'b0, 8'd0, 3'd1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0}},
      // both timers started just before the millisecond counter wraps
      '{'{32'hFFFF_FA00, 1'b1, 1'b0, 1'b1, 1'b1, 10'd300, 1'b0, 16'd1}, 1'b0, FREE},
      '{'{32'd499, 1'b1, 1'b0, 1'b1, 1'b1, 10'd300, 1'b0, 16'd1}, 1'b0, FREE},
      '{'{32'd1464, 1'b1, 1'b0, 1'b1, 1'b1, 10'd300, 1'b0, 16'd1}, 1'b0, FREE},
      '{'{32'd1465, 1'b1, 1'b0, 1'b1, 1'b0, 10'd300, 1'b0, 16'd0}, 1'b0, FREE}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   ebis_req_if req_bus ();
   ebis_rsp_if rsp_bus ();

   engine_board_input_supervisor u_top (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Bench copy of the registers and of the two elapsed-time trackers
   cfg_type           board_cfg;
   logic              tip_armed;
   logic [TIME_W-1:0] tip_since;
   logic              run_armed;
   logic [TIME_W-1:0] run_since;

   // Words offered but not yet taken, and status words awaited
   probe_row_type offered_q [$];
   result_type    pending_status_q [$];

   int samples_taken  = 0;
   int statuses_seen  = 0;
   int mismatch_count = 0;
   int quiet_cycles   = 0;
   int tip_cutoffs    = 0;
   int heater_words   = 0;

   int send_idle_pct    = 0;
   int rsp_stall_pct    = 0;
   int rsp_hold_request = 0;

   // Drive-session state used to build well-formed sample sequences
   logic [TIME_W-1:0] trip_now;
   logic              trip_tip;
   logic              trip_run;
   logic              trip_neutral;
   logic              trip_clutch;
   logic              trip_fresh;

   // Work out the status word for one sample and advance the timers.
   function automatic result_type predict_status(sample_type s);
      result_type        r;
      logic [TIME_W-1:0] lapse;
      int                g;
      r = '0;
      r.in_neutral    = !s.neutral_level;
      r.clutch_pulled = (s.clutch_level == board_cfg.clutch_active_high);
      r.driver_fault  = !s.fault_level;
      r.gear_raw      = TH_W'((32'(s.gear_adc) * 32'd255) / 32'd1023);
      r.gear          = '0;
      if (!r.in_neutral) begin
         // walk down so the lowest passing gear wins
         r.gear = GEAR_W'(NUM_GEARS);
         for (g = int'(NUM_GEARS) - 1; g >= 0; g--) begin
            if (r.gear_raw <= board_cfg.gear_thresholds[TH_W*g +: TH_W]) begin
               r.gear = GEAR_W'(g + 1);
            end
         end
      end
      if (s.tipover_level == board_cfg.tipover_active_high) begin
         if (!tip_armed) begin
            tip_armed = 1'b1;
            tip_since = s.now_ms;
         end
         lapse = s.now_ms - tip_since;
         r.tipped_over = (lapse >= TIME_W'(board_cfg.tip_debounce_ms));
      end else begin
         tip_armed = 1'b0;
         tip_since = '0;
      end
      r.outputs_enabled = !r.tipped_over;
      r.fault_lamp_on   = (s.now_ms < TIME_W'(board_cfg.bulb_check_ms))
                          || s.engine_protect_active || r.driver_fault
                          || r.tipped_over;
      if (s.engine_rpm != '0) begin
         if (!run_armed) begin
            run_armed = 1'b1;
            run_since = s.now_ms;
         end
         lapse = s.now_ms - run_since;
         r.o2_heater_on = (lapse >= TIME_W'(board_cfg.heater_delay_ms));
      end else begin
         run_armed = 1'b0;
         run_since = '0;
      end
      r.publish_gear = (board_cfg.speed_based_gear_mode == '0);
      return r;
   endfunction

   // Settings of one phase: both extremes, the reset values, then random.
   function automatic cfg_type settings_for_phase(int phase);
      cfg_type c;
      int      acc;
      int      g;
      c.clutch_active_high    = 1'($urandom_range(1));
      c.tipover_active_high   = 1'($urandom_range(1));
      c.speed_based_gear_mode = MODE_W'($urandom_range(3));
      c.tip_debounce_ms       = MS_W'($urandom_range(400));
      c.bulb_check_ms         = MS_W'($urandom_range(65535));
      c.heater_delay_ms       = MS_W'($urandom_range(600));
      if ($urandom_range(1) == 0) begin
         c.gear_thresholds = CSR_DATA_W'({$urandom, $urandom});
      end else begin
         // rising thresholds, as a real sensor calibration would be
         acc = 0;
         for (g = 0; g < int'(NUM_GEARS); g++) begin
            acc = acc + int'($urandom_range(60));
            if (acc > 255) acc = 255;
            c.gear_thresholds[TH_W*g +: TH_W] = TH_W'(acc);
         end
      end
      case (phase)
         0: c = '{1'b1, 1'b0, {CSR_DATA_W{1'b0}}, 2'd3, 16'd0, 16'd0, 16'd0};
         1: c = '{1'b0, 1'b1, {CSR_DATA_W{1'b1}}, 2'd1,
                  16'hFFFF, 16'hFFFF, 16'hFFFF};
         2: c = '{1'b0, 1'b1, GEAR_THRESH_RESET, 2'd0,
                  TIP_DEBOUNCE_RESET, BULB_CHECK_RESET, HEATER_DELAY_RESET};
         default: ;
      endcase
      return c;
   endfunction

   // Next sample: mostly a continuing drive session, some pure noise.
   function automatic sample_type next_sample();
      sample_type  s;
      logic [63:0] noise;
      int unsigned pick;
      if ($urandom_range(99) < 10) begin
         noise = {$urandom, $urandom};
         s = noise[$bits(sample_type)-1:0];
         return s;
      end
      if (trip_fresh || $urandom_range(99) == 0) begin
         // restart the session near init, near the wrap, or anywhere
         case ($urandom_range(2))
            0:       trip_now = TIME_W'($urandom_range(1500));
            1:       trip_now = 32'hFFFF_FFFF - TIME_W'($urandom_range(3000));
            default: trip_now = $urandom;
         endcase
         trip_tip     = 1'($urandom_range(1));
         trip_run     = 1'($urandom_range(1));
         trip_neutral = 1'($urandom_range(1));
         trip_clutch  = 1'($urandom_range(1));
         trip_fresh   = 1'b0;
      end
      pick = $urandom_range(99);
      if (pick < 80)      trip_now = trip_now + TIME_W'($urandom_range(40));
      else if (pick < 95) trip_now = trip_now + TIME_W'($urandom_range(2000));
      else                trip_now = trip_now + TIME_W'($urandom_range(70000));
      if ($urandom_range(99) < 4)  trip_tip     = !trip_tip;
      if ($urandom_range(99) < 4)  trip_run     = !trip_run;
      if ($urandom_range(99) < 5)  trip_neutral = !trip_neutral;
      if ($urandom_range(99) < 10) trip_clutch  = !trip_clutch;
      s.now_ms                = trip_now;
      s.neutral_level         = trip_neutral;
      s.clutch_level          = trip_clutch;
      s.fault_level           = ($urandom_range(99) >= 8);
      s.tipover_level         = trip_tip;
      s.gear_adc              = ADC_W'($urandom_range(1023));
      s.engine_protect_active = ($urandom_range(99) < 8);
      s.engine_rpm            = '0;
      if (trip_run) begin
         case ($urandom_range(3))
            0:       s.engine_rpm = 16'd1;
            1:       s.engine_rpm = 16'hFFFF;
            default: s.engine_rpm = RPM_W'($urandom_range(65535, 1));
         endcase
      end
      return s;
   endfunction

   // Write one register and track it in the bench copy; leave the enable up.
   task automatic write_register(logic [CSR_IDX_W-1:0] idx,
                                 logic [CSR_DATA_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         CSR_CLUTCH_POL:   board_cfg.clutch_active_high    = data[0];
         CSR_TIPOVER_POL:  board_cfg.tipover_active_high   = data[0];
         CSR_GEAR_THRESH:  board_cfg.gear_thresholds       = data;
         CSR_SPEED_MODE:   board_cfg.speed_based_gear_mode = data[MODE_W-1:0];
         CSR_TIP_DEBOUNCE: board_cfg.tip_debounce_ms       = data[MS_W-1:0];
         CSR_BULB_CHECK:   board_cfg.bulb_check_ms         = data[MS_W-1:0];
         CSR_HEATER_DELAY: board_cfg.heater_delay_ms       = data[MS_W-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // Program every register; with scramble set, fill unused upper bits with
   // junk and poke the unmapped index too.
   task automatic load_settings(cfg_type want, logic scramble);
      logic [CSR_DATA_W-1:0] junk;
      junk = scramble ? CSR_DATA_W'({$urandom, $urandom}) : '0;
      write_register(CSR_CLUTCH_POL,
                     {junk[CSR_DATA_W-1:1], want.clutch_active_high});
      write_register(CSR_TIPOVER_POL,
                     {junk[CSR_DATA_W-1:1], want.tipover_active_high});
      write_register(CSR_GEAR_THRESH, want.gear_thresholds);
      write_register(CSR_SPEED_MODE,
                     {junk[CSR_DATA_W-1:MODE_W], want.speed_based_gear_mode});
      write_register(CSR_TIP_DEBOUNCE,
                     {junk[CSR_DATA_W-1:MS_W], want.tip_debounce_ms});
      write_register(CSR_BULB_CHECK,
                     {junk[CSR_DATA_W-1:MS_W], want.bulb_check_ms});
      write_register(CSR_HEATER_DELAY,
                     {junk[CSR_DATA_W-1:MS_W], want.heater_delay_ms});
      if (scramble) write_register(CSR_UNMAPPED, junk);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   // Offer one word, with random idle gaps ahead of it; hold valid high
   // afterwards so back-to-back words need no second assignment.
   task automatic offer(probe_row_type row);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid                 <= 1'b1;
      req_bus.now_ms                <= row.stim.now_ms;
      req_bus.neutral_level         <= row.stim.neutral_level;
      req_bus.clutch_level          <= row.stim.clutch_level;
      req_bus.fault_level           <= row.stim.fault_level;
      req_bus.tipover_level         <= row.stim.tipover_level;
      req_bus.gear_adc              <= row.stim.gear_adc;
      req_bus.engine_protect_active <= row.stim.engine_protect_active;
      req_bus.engine_rpm            <= row.stim.engine_rpm;
      offered_q.push_back(row);
      do @(posedge clock); while (!req_bus.ready);
      samples_taken++;
   endtask

   // Drop valid and wait until every status word taken so far has come back.
   task automatic wait_until_drained();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (statuses_seen != samples_taken);
   endtask

   // Result side: random stalls, plus a long hold-off counted here when the
   // stimulus asks for one.
   initial begin : status_sink
      int hold_left;
      hold_left = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_request != 0) begin
            hold_left        = rsp_hold_request;
            rsp_hold_request = 0;
         end
         if (hold_left != 0) begin
            rsp_bus.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   // Watch both channels at each edge: check returned status words against
   // the oldest expectation first, then predict for a newly taken sample.
   always @(posedge clock) begin : channel_watch
      result_type    want;
      result_type    guess;
      probe_row_type taken;
      if (!reset) begin
         quiet_cycles++;
         if (rsp_bus.valid && rsp_bus.ready) begin
            quiet_cycles = 0;
            statuses_seen++;
            if (pending_status_q.size() == 0) begin
               $error("status word with no sample waiting for it");
               mismatch_count++;
            end else begin
               want = pending_status_q.pop_front();
               if (rsp_bus.in_neutral !== want.in_neutral) begin
                  $error("in_neutral: expected %0d, got %0d",
                         want.in_neutral, rsp_bus.in_neutral);
                  mismatch_count++;
               end
               if (rsp_bus.clutch_pulled !== want.clutch_pulled) begin
                  $error("clutch_pulled: expected %0d, got %0d",
                         want.clutch_pulled, rsp_bus.clutch_pulled);
                  mismatch_count++;
               end
               if (rsp_bus.driver_fault !== want.driver_fault) begin
                  $error("driver_fault: expected %0d, got %0d",
                         want.driver_fault, rsp_bus.driver_fault);
                  mismatch_count++;
               end
               if (rsp_bus.gear_raw !== want.gear_raw) begin
                  $error("gear_raw: expected %0d, got %0d",
                         want.gear_raw, rsp_bus.gear_raw);
                  mismatch_count++;
               end
               if (rsp_bus.gear !== want.gear) begin
                  $error("gear: expected %0d, got %0d", want.gear, rsp_bus.gear);
                  mismatch_count++;
               end
               if (rsp_bus.publish_gear !== want.publish_gear) begin
                  $error("publish_gear: expected %0d, got %0d",
                         want.publish_gear, rsp_bus.publish_gear);
                  mismatch_count++;
               end
               if (rsp_bus.tipped_over !== want.tipped_over) begin
                  $error("tipped_over: expected %0d, got %0d",
                         want.tipped_over, rsp_bus.tipped_over);
                  mismatch_count++;
               end
               if (rsp_bus.outputs_enabled !== want.outputs_enabled) begin
                  $error("outputs_enabled: expected %0d, got %0d",
                         want.outputs_enabled, rsp_bus.outputs_enabled);
                  mismatch_count++;
               end
               if (rsp_bus.fault_lamp_on !== want.fault_lamp_on) begin
                  $error("fault_lamp_on: expected %0d, got %0d",
                         want.fault_lamp_on, rsp_bus.fault_lamp_on);
                  mismatch_count++;
               end
               if (rsp_bus.o2_heater_on !== want.o2_heater_on) begin
                  $error("o2_heater_on: expected %0d, got %0d",
                         want.o2_heater_on, rsp_bus.o2_heater_on);
                  mismatch_count++;
               end
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            quiet_cycles = 0;
            taken = offered_q.pop_front();
            // always run the predictor so the timers stay in step
            guess = predict_status(taken.stim);
            want  = taken.pinned ? taken.status : guess;
            if (want.tipped_over)  tip_cutoffs++;
            if (want.o2_heater_on) heater_words++;
            pending_status_q.push_back(want);
         end
         // nothing moved on either channel for far too long
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("engine_board_input_supervisor: mismatch");
            $finish;
         end
      end
   end

   initial begin : stimulus
      int      row;
      int      phase;
      int      n;
      cfg_type want;
      req_bus.valid                 <= 1'b0;
      req_bus.now_ms                <= '0;
      req_bus.neutral_level         <= 1'b1;
      req_bus.clutch_level          <= 1'b0;
      req_bus.fault_level           <= 1'b1;
      req_bus.tipover_level         <= 1'b0;
      req_bus.gear_adc              <= '0;
      req_bus.engine_protect_active <= 1'b0;
      req_bus.engine_rpm            <= '0;
      csr_wr_en                     <= 1'b0;
      csr_index                     <= '0;
      csr_wdata                     <= '0;

      // bench copy starts from the reset values
      board_cfg = '{1'b0, 1'b1, GEAR_THRESH_RESET, 2'd0,
                    TIP_DEBOUNCE_RESET, BULB_CHECK_RESET, HEATER_DELAY_RESET};
      tip_armed  = 1'b0;
      tip_since  = '0;
      run_armed  = 1'b0;
      run_since  = '0;
      trip_now   = '0;
      trip_tip   = 1'b0;
      trip_run   = 1'b0;
      trip_neutral = 1'b1;
      trip_clutch  = 1'b0;
      trip_fresh = 1'b1;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed words under the reset settings, no idling
      for (row = 0; row < PROBE_COUNT; row++) begin
         offer(PROBE_ROWS[row]);
      end
      wait_until_drained();

      // Random phases: new settings each time, idling mode cycles through
      // none, sender only, receiver only, and both.
      for (phase = 0; phase < PHASES; phase++) begin
         case (phase % 4)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 50; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 50; end
            default: begin send_idle_pct = 38; rsp_stall_pct = 38; end
         endcase
         want = settings_for_phase(phase);
         load_settings(want, phase >= 3);
         trip_fresh = 1'b1;
         for (n = 0; n < PHASE_WORDS; n++) begin
            // hold the result side off long enough to back up the input
            if (phase == 4 && n == 80) rsp_hold_request = 400;
            // pause the sender until everything in flight has come back
            if (phase == 5 && n == 120) wait_until_drained();
            offer('{next_sample(), 1'b0, FREE});
         end
         wait_until_drained();
      end

      // everything is back; let the two-stage pipe sit idle
      repeat (4) @(posedge clock);
      if (pending_status_q.size() != 0) begin
         $error("%0d status words never arrived", pending_status_q.size());
         mismatch_count++;
      end

      $display("run covered %0d samples over %0d settings phases and %0d statuses",
               samples_taken, PHASES, statuses_seen);
      $display("  with %0d tip-over cut-off words and %0d heater-on words",
               tip_cutoffs, heater_words);
      if (mismatch_count == 0) begin
         $display("engine_board_input_supervisor: match");
      end else begin
         $display("engine_board_input_supervisor: mismatch");
      end
      $finish;
   end

endmodule

FILE: files.f
rtl/core/ebis_pkg.sv
rtl/core/ebis_if.sv
rtl/core/ebis_csr.sv
rtl/core/ebis_decode.sv
rtl/core/ebis_timer.sv
rtl/core/engine_board_input_supervisor.sv
test/engine_board_input_supervisor_test.sv
